### rtl/tmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_pkg
// Types and codes shared by the timed message queue and its cells.
// ----------------------------------------------------------------------------
package tmq_pkg;

    typedef enum logic [2:0] {
        ACT_ENQ      = 3'd0,
        ACT_DEQ      = 3'd1,
        ACT_RM_HDL   = 3'd2,
        ACT_RM_WHAT  = 3'd3,
        ACT_RM_ID    = 3'd4,
        ACT_QUIT     = 3'd5,
        ACT_RSVD6    = 3'd6,
        ACT_RSVD7    = 3'd7
    } t_action;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_HDL  = 3'd1;
    localparam logic [2:0] ST_QUIT    = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [63:0] due;
        logic [7:0]  handler;
        logic [31:0] what;
        logic [7:0]  id;
    } t_slot;

    // Per-cycle command broadcast to every cell.
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_INS   = 2'd1,
        OP_SHL   = 2'd2,
        OP_SQZ   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] due;
        logic [7:0]  handler;
        logic [31:0] what;
        logic [7:0]  id;
    } t_cell_cmd;

endpackage : tmq_pkg
`default_nettype wire

### rtl/tmq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_cell
// One queue slot. Inserts, shifts toward the head, or squeezes out a hit.
// ----------------------------------------------------------------------------
module tmq_cell
    import tmq_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_cell_cmd i_cmd,
    input  wire       i_ins_here,   // new word lands in this slot
    input  wire       i_from_prev,  // take predecessor (insert shift)
    input  wire       i_from_next,  // take successor (pop / squeeze)
    input  t_slot     i_prev,
    input  t_slot     i_next,
    output t_slot     o_slot
);
    t_slot r_slot, n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ins_here) begin
            n_slot = '{valid: 1'b1, due: i_cmd.due, handler: i_cmd.handler,
                       what: i_cmd.what, id: i_cmd.id};
        end else if (i_from_prev) begin
            n_slot = i_prev;
        end else if (i_from_next) begin
            n_slot = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.due     <= n_slot.due;
        r_slot.handler <= n_slot.handler;
        r_slot.what    <= n_slot.what;
        r_slot.id      <= n_slot.id;
    end

    assign o_slot = r_slot;
endmodule : tmq_cell
`default_nettype wire

### rtl/timed_message_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_message_queue
// Bounded timer queue held as a sorted row of slot cells.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Word
// command | in        | i_start / o_busy   | action, time, handler, what, id
// result  | out       | o_done (1 cycle)   | ok, status, message, queue view
//
// Enqueue, dequeue, quit and unused actions decode and update the cells in
// one step (S_EXEC), then give the result. Removals squeeze out one matching
// slot per cycle, walking the row once: the decode (S_EXEC), a walk step in
// S_WALK for each queued slot, a step to see the end of the row, then the
// result (S_DONE). The walk length is set by the single compaction point
// shared by the cell row.
// Reset (synchronous, active low) clears every slot valid bit and the quit
// flag at once; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module timed_message_queue
    import tmq_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    output logic              o_busy,
    input  wire        [2:0]  i_action,
    input  wire        [63:0] i_time_value,
    input  wire        [7:0]  i_handler_id,
    input  wire signed [31:0] i_what_code,
    input  wire        [7:0]  i_msg_id,
    output logic              o_done,
    output logic              o_ok,
    output logic       [2:0]  o_status,
    output logic       [7:0]  o_out_msg_id,
    output logic       [7:0]  o_out_handler,
    output logic signed [31:0] o_out_what,
    output logic       [63:0] o_out_due,
    output logic              o_queue_empty,
    output logic       [63:0] o_next_due
);
    localparam int IW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Latched command word
    t_action     r_act;
    logic [63:0] r_tv;
    logic [7:0]  r_h, r_id;
    logic [31:0] r_w;
    logic        r_quit;
    logic        r_found;
    logic [IW-1:0] r_idx;  // walk position

    t_slot slots [ENTRIES];
    t_cell_cmd cmd;
    logic [ENTRIES-1:0] ins_here, from_prev, from_next;

    // Comparisons across the row, one per cell
    logic [ENTRIES-1:0] le_vec, dup_vec, valid_vec;
    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            valid_vec[k] = slots[k].valid;
            le_vec[k]    = slots[k].valid && (slots[k].due <= r_tv);
            dup_vec[k]   = slots[k].valid && (slots[k].id == r_id);
        end
    end

    wire full = valid_vec[ENTRIES-1];
    wire empty = !valid_vec[0];
    wire head_due = !empty && (r_tv >= slots[0].due);

    // Slot at walk index; row is small, read through a mux
    t_slot cur;
    logic  cur_hit;
    always_comb begin
        cur = slots[r_idx[$clog2(ENTRIES)-1:0]];
        cur_hit = cur.valid && (cur.handler == r_h);
        if (r_act == ACT_RM_WHAT) cur_hit = cur_hit && (cur.what == r_w);
        if (r_act == ACT_RM_ID)   cur_hit = cur_hit && (cur.id == r_id) && !r_found;
    end
    wire walk_end = (r_idx >= IW'(ENTRIES)) || !cur.valid;

    // Result staging
    logic       n_ok;
    logic [2:0] n_status;
    logic       r_ok;
    logic [2:0] r_status;
    t_slot      r_pop, n_pop;

    always_comb begin
        n_state  = r_state;
        cmd      = '{op: OP_HOLD, due: r_tv, handler: r_h, what: r_w, id: r_id};
        ins_here = '0; from_prev = '0; from_next = '0;
        n_ok = r_ok; n_status = r_status; n_pop = r_pop;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_EXEC;
            S_EXEC: begin
                n_ok = 1'b0; n_status = ST_NONE; n_pop = '0;
                n_state = S_DONE;
                case (r_act)
                    ACT_ENQ: begin
                        if (r_h == 8'd0)       n_status = ST_NO_HDL;
                        else if (r_quit)       n_status = ST_QUIT;
                        else if (|dup_vec)     n_status = ST_DUP;
                        else if (full)         n_status = ST_FULL;
                        else begin
                            n_ok = 1'b1; n_status = ST_OK;
                            cmd.op = OP_INS;
                            // insert after the last slot due at or before time
                            for (int k = 0; k < ENTRIES; k++) begin
                                ins_here[k] = !le_vec[k] &&
                                    ((k == 0) ? 1'b1 : le_vec[k-1]);
                                from_prev[k] = (k != 0) && !le_vec[k] &&
                                    ((k == 0) ? 1'b0 : !le_vec[k-1]) &&
                                    ((k == 0) ? 1'b0 : valid_vec[k-1]);
                            end
                        end
                    end
                    ACT_DEQ: begin
                        if (r_quit) n_status = ST_QUIT;
                        else if (head_due) begin
                            n_ok = 1'b1; n_status = ST_OK;
                            n_pop = slots[0];
                            cmd.op = OP_SHL;
                            from_next = '1;
                        end
                    end
                    ACT_RM_HDL, ACT_RM_WHAT, ACT_RM_ID: begin
                        if (r_h == 8'd0) n_status = ST_NO_HDL;
                        else n_state = S_WALK;
                    end
                    ACT_QUIT: begin
                        n_ok = 1'b1; n_status = ST_OK;
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                if (walk_end) begin
                    n_ok = r_found; n_status = r_found ? ST_OK : ST_NONE;
                    n_state = S_DONE;
                end else if (cur_hit) begin
                    // squeeze out this slot: all cells from here take successor
                    cmd.op = OP_SQZ;
                    for (int k = 0; k < ENTRIES; k++)
                        from_next[k] = (IW'(k) >= r_idx);
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Cell row; the tail cell takes an empty slot from beyond the end
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tmq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_ins_here (ins_here[g]),
            .i_from_prev(from_prev[g]),
            .i_from_next(from_next[g]),
            .i_prev     ((g == 0) ? slots[0] : slots[(g == 0) ? 0 : g-1]),
            .i_next     ((g == ENTRIES-1) ? t_slot'('0)
                                          : slots[(g == ENTRIES-1) ? g : g+1]),
            .o_slot     (slots[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_quit  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC && r_act == ACT_QUIT) r_quit <= 1'b1;
        end
        if (r_state == S_IDLE && i_start) begin
            r_act <= t_action'(i_action);
            r_tv  <= i_time_value;
            r_h   <= i_handler_id;
            r_w   <= i_what_code;
            r_id  <= i_msg_id;
            r_found <= 1'b0;
            r_idx <= '0;
        end else if (r_state == S_WALK && !walk_end) begin
            // hold index on a hit: the successor slides into place
            if (cur_hit) r_found <= 1'b1;
            else         r_idx <= r_idx + IW'(1);
        end
        r_ok     <= n_ok;
        r_status <= n_status;
        r_pop    <= n_pop;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_ok          = r_ok;
    assign o_status      = r_status;
    assign o_out_msg_id  = r_pop.id;
    assign o_out_handler = r_pop.handler;
    assign o_out_what    = r_pop.what;
    assign o_out_due     = r_pop.due;
    assign o_queue_empty = empty;
    assign o_next_due    = empty ? 64'd0 : slots[0].due;

    // Valid slots stay a prefix of the row
    for (genvar a = 1; a < ENTRIES; a++) begin : g_chk
        a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            slots[a].valid |-> slots[a-1].valid)
            else $error("slot hole");
    end
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double result");
    a_quit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_quit) |-> r_quit) else $error("quit lost");
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_ok == (o_status == ST_OK))) else $error("ok mismatch");
endmodule : timed_message_queue
`default_nettype wire
